[sv/conv_bn_activation_stage_assert.svh]
// Assertion macros shared by the port checker of conv_bn_activation_stage.
`ifndef CONV_BN_ACTIVATION_STAGE_ASSERT_SVH
`define CONV_BN_ACTIVATION_STAGE_ASSERT_SVH

// Check a property at every rising clock edge, reset included.
`define CBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

// Check a same-cycle implication outside reset.
`define CBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication outside reset.
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/cba_pkg.sv]
// Shared types and constants of the conv / batch-norm / activation stage.
package cba_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SUM_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SUM_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SUM_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SUM_SHIFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_PER_INPUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_PER_GROUP = 3'd5;

    // item kinds
    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    // corrected accumulator fits 52 bits signed for all register values
    localparam int ACC_W = 52;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                    is_load;
        logic signed [ACC_W-1:0] acc;
        logic signed [23:0]      bn_mul;
        logic signed [31:0]      bn_add;
        logic [3:0]              bn_shift;
        logic [3:0]              seg_index;
        logic [59:0]             seg_word;
        logic [7:0]              seg_offset;
    } q_item_t;

endpackage

[sv/cba_front.sv]
// Front part: configuration registers, item intake and zero-point correction.
module cba_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic                            action,
    input  logic [29:0]                     dot_product,
    input  logic [21:0]                     sum_inputs,
    input  logic [21:0]                     sum_weights,
    input  logic signed [23:0]              bn_mul,
    input  logic signed [31:0]              bn_add,
    input  logic [3:0]                      bn_shift,
    input  logic [3:0]                      segment_index,
    input  logic [59:0]                     segment_word,
    input  logic [7:0]                      segment_offset,
    output logic                            q_push,
    output cba_pkg::q_item_t                q_item,
    input  logic                            q_full
);
    import cba_pkg::*;

    logic signed [23:0] wgain_reg, wgain_next;
    logic signed [23:0] igain_reg, igain_next;
    logic [3:0]         wshift_reg, wshift_next;
    logic [3:0]         ishift_reg, ishift_next;
    logic signed [39:0] bias_reg, bias_next;
    logic [10:0]        ipg_reg, ipg_next;

    logic               adv;
    logic               f1_valid_reg, f1_valid_next;
    logic               f2_valid_reg, f2_valid_next;
    q_item_t            f1_item_reg, f1_item_next;
    q_item_t            f2_item_reg, f2_item_next;
    logic [29:0]        f1_dot_reg, f1_dot_next;
    logic signed [46:0] f1_pin_reg, f1_pin_next;
    logic signed [46:0] f1_pw_reg, f1_pw_next;
    logic signed [ACC_W-1:0] f1_pb_reg, f1_pb_next;
    logic signed [ACC_W-1:0] acc_sum;

    always_comb
    begin
        wgain_next  = wgain_reg;
        igain_next  = igain_reg;
        wshift_next = wshift_reg;
        ishift_next = ishift_reg;
        bias_next   = bias_reg;
        ipg_next    = ipg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_SUM_GAIN:  wgain_next  = cfg_wdata[23:0];
                CFG_INPUT_SUM_GAIN:   igain_next  = cfg_wdata[23:0];
                CFG_WEIGHT_SUM_SHIFT: wshift_next = cfg_wdata[3:0];
                CFG_INPUT_SUM_SHIFT:  ishift_next = cfg_wdata[3:0];
                CFG_BIAS_PER_INPUT:   bias_next   = cfg_wdata[39:0];
                CFG_INPUTS_PER_GROUP: ipg_next    = cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgain_reg  <= '0;
            igain_reg  <= '0;
            wshift_reg <= '0;
            ishift_reg <= '0;
            bias_reg   <= '0;
            ipg_reg    <= 11'd1;
        end
        else
        begin
            wgain_reg  <= wgain_next;
            igain_reg  <= igain_next;
            wshift_reg <= wshift_next;
            ishift_reg <= ishift_next;
            bias_reg   <= bias_next;
            ipg_reg    <= ipg_next;
        end
    end

    // Hold both stages while the second one cannot hand its item to the queue.
    assign adv    = !(f2_valid_reg && q_full);
    assign full   = !adv;
    assign q_push = f2_valid_reg && !q_full;
    assign q_item = f2_item_reg;

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        f2_valid_next = f2_valid_reg;
        if (adv)
        begin
            f1_valid_next = push;
            f2_valid_next = f1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    // Stage 1: classify and form the three correction products.
    always_comb
    begin
        f1_item_next.is_load    = (action == ACT_LOAD);
        f1_item_next.acc        = '0;
        f1_item_next.bn_mul     = bn_mul;
        f1_item_next.bn_add     = bn_add;
        f1_item_next.bn_shift   = bn_shift;
        f1_item_next.seg_index  = segment_index;
        f1_item_next.seg_word   = segment_word;
        f1_item_next.seg_offset = segment_offset;
        f1_dot_next = dot_product;
        f1_pin_next = igain_reg * $signed({1'b0, sum_inputs});
        f1_pw_next  = wgain_reg * $signed({1'b0, sum_weights});
        f1_pb_next  = bias_reg * $signed({1'b0, ipg_reg});
    end

    // Stage 2: shift the zero-point terms and sum everything.
    always_comb
    begin
        acc_sum = $signed(ACC_W'(f1_dot_reg))
                + ACC_W'(f1_pin_reg >>> ishift_reg)
                + ACC_W'(f1_pw_reg >>> wshift_reg)
                + f1_pb_reg;
        f2_item_next     = f1_item_reg;
        f2_item_next.acc = acc_sum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_item_reg <= f1_item_next;
            f1_dot_reg  <= f1_dot_next;
            f1_pin_reg  <= f1_pin_next;
            f1_pw_reg   <= f1_pw_next;
            f1_pb_reg   <= f1_pb_next;
            f2_item_reg <= f2_item_next;
        end
    end

endmodule

[sv/cba_queue.sv]
// Short queue that decouples the front part from the back part.
module cba_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  cba_pkg::q_item_t wr_item,
    output logic             full,
    input  logic             rd_en,
    output cba_pkg::q_item_t rd_item,
    output logic             empty
);
    import cba_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_item_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(do_wr);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_rd);
        count_next  = count_reg + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[sv/cba_back.sv]
// Back part: batch-norm, segment lookup, activation, clamp and result buffer.
module cba_back #(
    parameter int SEGMENTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cba_pkg::q_item_t q_item,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       activated
);
    import cba_pkg::*;

    localparam int SEG_W      = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int OBUF_DEPTH = 2;
    localparam int OPTR_W     = $clog2(OBUF_DEPTH);
    localparam int HI_W       = ACC_W - 32;

    function automatic logic signed [63:0] seg_start(input logic [59:0] word);
        return 64'($signed(word[59:24]));
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                       input logic [7:0] sh);
        logic [5:0]         s;
        logic signed [63:0] y;
        logic signed [63:0] half;
        logic signed [63:0] r;
        s    = (sh > 8'd63) ? 6'd63 : sh[5:0];
        y    = x >>> (s - 6'd1);
        half = y >>> 1;
        priority if (sh == 8'd0)
            r = x;
        else if (!y[0])
            r = half;
        else if (y[63])
            r = half - 64'sd1;
        else
            r = half + 64'sd1;
        return r;
    endfunction

    function automatic logic [7:0] clamp_byte(input logic signed [63:0] r);
        logic [7:0] b;
        priority if (r[63])
            b = 8'd0;
        else if (|r[62:8])
            b = 8'hff;
        else
            b = r[7:0];
        return b;
    endfunction

    // segment table, loaded in item order at the lookup stage
    logic [59:0] seg_word_reg [SEGMENTS];
    logic [7:0]  seg_off_reg  [SEGMENTS];
    logic        tbl_we;

    logic adv;
    logic b1_valid_reg, b1_valid_next, b2_valid_reg, b2_valid_next;
    logic b3_valid_reg, b3_valid_next, b4_valid_reg, b4_valid_next;
    logic b5_valid_reg, b5_valid_next, b6_valid_reg, b6_valid_next;
    logic b7_valid_reg, b7_valid_next, b8_valid_reg, b8_valid_next;

    q_item_t                  b1_item_reg, b2_item_reg, b3_item_reg;
    logic signed [56:0]       b1_pplo_reg, b1_pplo_next;
    logic signed [HI_W+23:0]  b1_pphi_reg, b1_pphi_next;
    logic signed [63:0]       b2_prod_reg, b2_prod_next;
    logic signed [63:0]       b3_v_reg, b3_v_next;
    logic [SEG_W-1:0]         sel;
    logic signed [63:0]       b4_v_reg;
    logic [59:0]              b4_word_reg, b4_word_next;
    logic [7:0]               b4_off_reg, b4_off_next;
    logic signed [63:0]       b5_diff_reg, b5_diff_next;
    logic signed [15:0]       b5_slope_reg, b5_slope_next;
    logic [7:0]               b5_sh_reg, b5_off_reg;
    logic signed [48:0]       b6_pplo_reg, b6_pplo_next;
    logic signed [47:0]       b6_pphi_reg, b6_pphi_next;
    logic [7:0]               b6_sh_reg, b6_off_reg;
    logic signed [63:0]       b7_prod_reg, b7_prod_next;
    logic [7:0]               b7_sh_reg, b7_off_reg;
    logic signed [63:0]       b8_r_reg, b8_r_next;
    logic [7:0]               b8_off_reg;

    logic [7:0]        obuf_reg [OBUF_DEPTH];
    logic [OPTR_W-1:0] owr_ptr_reg, owr_ptr_next, ord_ptr_reg, ord_ptr_next;
    logic [OPTR_W:0]   ocount_reg, ocount_next;
    logic              obuf_full;
    logic              o_wr;
    logic              o_rd;
    logic [7:0]        o_byte;

    // Stall the whole pipe only while a finished result finds the buffer full.
    assign obuf_full = (ocount_reg == (OPTR_W+1)'(OBUF_DEPTH));
    assign adv       = !(b8_valid_reg && obuf_full);
    assign q_pop     = adv && !q_empty;
    assign o_wr      = b8_valid_reg && !obuf_full;
    assign empty     = (ocount_reg == '0);
    assign o_rd      = pop && !empty;
    assign activated = obuf_reg[ord_ptr_reg];

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        b2_valid_next = b2_valid_reg;
        b3_valid_next = b3_valid_reg;
        b4_valid_next = b4_valid_reg;
        b5_valid_next = b5_valid_reg;
        b6_valid_next = b6_valid_reg;
        b7_valid_next = b7_valid_reg;
        b8_valid_next = b8_valid_reg;
        if (adv)
        begin
            b1_valid_next = !q_empty;
            b2_valid_next = b1_valid_reg;
            b3_valid_next = b2_valid_reg;
            // drop load items once they have written the table
            b4_valid_next = b3_valid_reg && !b3_item_reg.is_load;
            b5_valid_next = b4_valid_reg;
            b6_valid_next = b5_valid_reg;
            b7_valid_next = b6_valid_reg;
            b8_valid_next = b7_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
            b7_valid_reg <= 1'b0;
            b8_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
            b2_valid_reg <= b2_valid_next;
            b3_valid_reg <= b3_valid_next;
            b4_valid_reg <= b4_valid_next;
            b5_valid_reg <= b5_valid_next;
            b6_valid_reg <= b6_valid_next;
            b7_valid_reg <= b7_valid_next;
            b8_valid_reg <= b8_valid_next;
        end
    end

    always_comb
    begin
        // batch-norm multiply split in a low unsigned and a high signed half
        b1_pplo_next = $signed({1'b0, q_item.acc[31:0]}) * q_item.bn_mul;
        b1_pphi_next = $signed(q_item.acc[ACC_W-1:32]) * q_item.bn_mul;
        b2_prod_next = (64'(b1_pphi_reg) <<< 32) + 64'(b1_pplo_reg);
        b3_v_next    = (b2_prod_reg >>> b2_item_reg.bn_shift)
                     + 64'($signed(b2_item_reg.bn_add));
    end

    // Pick the highest segment whose start is at or below the value.
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            if (seg_start(seg_word_reg[i]) <= b3_v_reg)
            begin
                sel = SEG_W'(i);
            end
        end
        b4_word_next = seg_word_reg[sel];
        b4_off_next  = seg_off_reg[sel];
    end

    assign tbl_we = adv && b3_valid_reg && b3_item_reg.is_load
                 && (int'(b3_item_reg.seg_index) < SEGMENTS);

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            seg_word_reg[SEG_W'(b3_item_reg.seg_index)] <= b3_item_reg.seg_word;
            seg_off_reg[SEG_W'(b3_item_reg.seg_index)]  <= b3_item_reg.seg_offset;
        end
    end

    always_comb
    begin
        b5_diff_next  = b4_v_reg - seg_start(b4_word_reg);
        b5_slope_next = $signed(b4_word_reg[23:8]);
        b6_pplo_next  = $signed({1'b0, b5_diff_reg[31:0]}) * b5_slope_reg;
        b6_pphi_next  = $signed(b5_diff_reg[63:32]) * b5_slope_reg;
        b7_prod_next  = (64'(b6_pphi_reg) <<< 32) + 64'(b6_pplo_reg);
        b8_r_next     = round_shift(b7_prod_reg, b7_sh_reg);
        o_byte        = clamp_byte(b8_r_reg + $signed({56'd0, b8_off_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_item_reg  <= q_item;
            b1_pplo_reg  <= b1_pplo_next;
            b1_pphi_reg  <= b1_pphi_next;
            b2_item_reg  <= b1_item_reg;
            b2_prod_reg  <= b2_prod_next;
            b3_item_reg  <= b2_item_reg;
            b3_v_reg     <= b3_v_next;
            b4_v_reg     <= b3_v_reg;
            b4_word_reg  <= b4_word_next;
            b4_off_reg   <= b4_off_next;
            b5_diff_reg  <= b5_diff_next;
            b5_slope_reg <= b5_slope_next;
            b5_sh_reg    <= b4_word_reg[7:0];
            b5_off_reg   <= b4_off_reg;
            b6_pplo_reg  <= b6_pplo_next;
            b6_pphi_reg  <= b6_pphi_next;
            b6_sh_reg    <= b5_sh_reg;
            b6_off_reg   <= b5_off_reg;
            b7_prod_reg  <= b7_prod_next;
            b7_sh_reg    <= b6_sh_reg;
            b7_off_reg   <= b6_off_reg;
            b8_r_reg     <= b8_r_next;
            b8_off_reg   <= b7_off_reg;
        end
    end

    // result buffer
    always_comb
    begin
        owr_ptr_next = owr_ptr_reg + OPTR_W'(o_wr);
        ord_ptr_next = ord_ptr_reg + OPTR_W'(o_rd);
        ocount_next  = ocount_reg + (OPTR_W+1)'(o_wr) - (OPTR_W+1)'(o_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocount_reg  <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_wr)
        begin
            obuf_reg[owr_ptr_reg] <= o_byte;
        end
    end

endmodule

[sv/conv_bn_activation_stage.sv]
// Quantized convolution output stage: zero-point correction, bias, batch-norm,
// piecewise-linear activation and clamp to a byte. Accepts one item per clock
// (push while full is low) and delivers one result per clock (pop while empty
// is low); an accumulator item yields its byte, in the order of transfer, and a
// load item writes one segment of the table and yields nothing. The
// front part (two stages: correction products, then the corrected sum) feeds a
// four-entry queue; the back part is an eight-stage pipe (batch-norm multiply in
// two halves, shift and add, segment lookup, difference, slope multiply in two
// halves, rounding shift) followed by a two-entry result buffer. Loads update
// the segment table at the lookup stage, so every accumulator sees exactly the
// loads transferred before it. The back pipe holds only while a result finds
// the buffer full; full rises once the queue has filled as well. Write the
// configuration registers only while the block is idle, and load every segment
// before the first accumulator.
module conv_bn_activation_stage #(
    parameter int SEGMENTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic                            action,
    input  logic [29:0]                     dot_product,
    input  logic [21:0]                     sum_inputs,
    input  logic [21:0]                     sum_weights,
    input  logic signed [23:0]              bn_mul,
    input  logic signed [31:0]              bn_add,
    input  logic [3:0]                      bn_shift,
    input  logic [3:0]                      segment_index,
    input  logic [59:0]                     segment_word,
    input  logic [7:0]                      segment_offset,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      activated
);
    import cba_pkg::*;

    q_item_t fq_item;
    q_item_t qb_item;
    logic    fq_push;
    logic    fq_full;
    logic    qb_pop;
    logic    qb_empty;

    // Intake, configuration and accumulator correction.
    cba_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .action         (action),
        .dot_product    (dot_product),
        .sum_inputs     (sum_inputs),
        .sum_weights    (sum_weights),
        .bn_mul         (bn_mul),
        .bn_add         (bn_add),
        .bn_shift       (bn_shift),
        .segment_index  (segment_index),
        .segment_word   (segment_word),
        .segment_offset (segment_offset),
        .q_push         (fq_push),
        .q_item         (fq_item),
        .q_full         (fq_full)
    );

    // Absorb short stalls of the back part.
    cba_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_item (fq_item),
        .full    (fq_full),
        .rd_en   (qb_pop),
        .rd_item (qb_item),
        .empty   (qb_empty)
    );

    // Batch-norm, activation and result buffer.
    cba_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (qb_empty),
        .q_item    (qb_item),
        .q_pop     (qb_pop),
        .empty     (empty),
        .pop       (pop),
        .activated (activated)
    );

endmodule

[sv/cba_port_checker.sv]
// Port-level checker for conv_bn_activation_stage and its bind statement.
`include "conv_bn_activation_stage_assert.svh"

module cba_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] activated
);

    // Reset leaves no result and room for input.
    `CBA_ASSERT_ALWAYS(a_reset_idle, clk, $rose(rst_n) |-> (empty && !full), "reset state not idle")

    // Full can only come up from an item transferred earlier.
    `CBA_ASSERT_IMPL(a_full_source, clk, rst_n, $rose(full) && !$past(full, 2),
        $past(push, 2), "full without a transfer")

    // Hold a waiting result until it is popped.
    `CBA_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop,
        !empty && $stable(activated), "result dropped")

endmodule

bind conv_bn_activation_stage cba_port_checker u_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .activated (activated)
);

[tb/sv/tb_top.sv]
// Self-checking testbench of conv_bn_activation_stage with a bit-true output predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cba_pkg::*;

    localparam int SEG_COUNT     = 16;
    localparam int RESET_CYCLES  = 6;
    // long enough for the pipe to drain, so a trailing load has landed too
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_ITEM  = 45;
    localparam int PHASE_ITEMS   = 72;
    localparam int PHASE_COUNT   = 6;
    localparam int MAX_PRINTED   = 100;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        SET_TAME,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_GROUP_ZERO,
        SET_GROUP_WIDE,
        SET_RANDOM
    } reg_setting_t;

    // register settings of the random phases, in run order
    localparam reg_setting_t PHASE_PLAN [PHASE_COUNT] = '{
        SET_TAME, SET_ALL_MAX, SET_GROUP_ZERO, SET_ALL_MIN, SET_GROUP_WIDE, SET_RANDOM
    };

    typedef struct {
        logic               action;
        logic [29:0]        dot_product;
        logic [21:0]        sum_inputs;
        logic [21:0]        sum_weights;
        logic signed [23:0] bn_mul;
        logic signed [31:0] bn_add;
        logic [3:0]         bn_shift;
        logic [3:0]         segment_index;
        logic [59:0]        segment_word;
        logic [7:0]         segment_offset;
    } stage_item_t;

    // ------------------------------------------------------------------
    // Block ports; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  push           = 1'b0;
    logic                  action         = ACT_PROCESS;
    logic [29:0]           dot_product    = '0;
    logic [21:0]           sum_inputs     = '0;
    logic [21:0]           sum_weights    = '0;
    logic signed [23:0]    bn_mul         = '0;
    logic signed [31:0]    bn_add         = '0;
    logic [3:0]            bn_shift       = '0;
    logic [3:0]            segment_index  = '0;
    logic [59:0]           segment_word   = '0;
    logic [7:0]            segment_offset = '0;
    logic                  pop            = 1'b0;
    logic                  full;
    logic                  empty;
    logic [7:0]            activated;

    // ------------------------------------------------------------------
    // Predictor state: the register file and the segment table as the
    // block should hold them after every accepted transfer.
    // ------------------------------------------------------------------
    logic signed [23:0] wsum_gain    = '0;
    logic signed [23:0] isum_gain    = '0;
    logic [3:0]         wsum_shift   = '0;
    logic [3:0]         isum_shift   = '0;
    logic signed [39:0] bias_each    = '0;
    logic [10:0]        group_inputs = 11'd1;
    logic [59:0]        seg_words [SEG_COUNT] = '{default: '0};
    logic [7:0]         seg_offs  [SEG_COUNT] = '{default: '0};

    stage_item_t pending_items [$];   // items still to be offered, oldest first
    logic [7:0]  expected_bytes [$];  // predicted output bytes, oldest first
    stage_item_t offered;             // item currently on the input ports

    int send_idle_pct = 15;
    int recv_idle_pct = 81;
    int items_in      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int mismatches    = 0;
    int cycle_count   = 0;

    conv_bn_activation_stage #(
        .SEGMENTS       (SEG_COUNT)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .action         (action),
        .dot_product    (dot_product),
        .sum_inputs     (sum_inputs),
        .sum_weights    (sum_weights),
        .bn_mul         (bn_mul),
        .bn_add         (bn_add),
        .bn_shift       (bn_shift),
        .segment_index  (segment_index),
        .segment_word   (segment_word),
        .segment_offset (segment_offset),
        .empty          (empty),
        .pop            (pop),
        .activated      (activated)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_pm(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Fill every field at random; fields the item kind ignores stay noisy.
    function automatic stage_item_t random_item();
        stage_item_t it;
        it.action         = 1'($urandom);
        it.dot_product    = 30'($urandom);
        it.sum_inputs     = 22'($urandom);
        it.sum_weights    = 22'($urandom);
        it.bn_mul         = 24'($urandom);
        it.bn_add         = 32'($urandom);
        it.bn_shift       = 4'($urandom);
        it.segment_index  = 4'($urandom);
        it.segment_word   = 60'({$urandom, $urandom});
        it.segment_offset = 8'($urandom);
        return it;
    endfunction

    // Segment i starts at (i-8)*2^28, so segments tile the range that the
    // batch-norm addend alone can reach; slope and shift keep most outputs
    // inside the byte instead of saturating.
    function automatic stage_item_t tame_segment(input int idx);
        stage_item_t        it;
        longint             seg_start;
        logic signed [15:0] slope;
        it               = random_item();
        it.action        = ACT_LOAD;
        seg_start        = longint'(idx - 8) <<< 28;
        slope            = 16'(rand_pm(15));
        it.segment_index = 4'(idx);
        it.segment_word  = {seg_start[35:0], slope, 8'($urandom_range(22, 27))};
        return it;
    endfunction

    // Small multiplier keeps the batch-norm result near the segment range.
    function automatic stage_item_t tame_process();
        stage_item_t it;
        it        = random_item();
        it.action = ACT_PROCESS;
        it.bn_mul = 24'(rand_pm(3));
        return it;
    endfunction

    function automatic stage_item_t process_item(input logic [29:0] dot, input logic [21:0] sx,
                                                 input logic [21:0] sw, input int mul,
                                                 input int add, input logic [3:0] shift);
        stage_item_t it;
        it             = random_item();
        it.action      = ACT_PROCESS;
        it.dot_product = dot;
        it.sum_inputs  = sx;
        it.sum_weights = sw;
        it.bn_mul      = 24'(mul);
        it.bn_add      = 32'(add);
        it.bn_shift    = shift;
        return it;
    endfunction

    // Mostly well-formed traffic: accumulators against a sane table, a few
    // table rewrites, and some fully random noise of both kinds.
    function automatic stage_item_t random_phase_item();
        stage_item_t it;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return tame_segment($urandom_range(0, SEG_COUNT - 1));
        if (roll < 10)
        begin
            it        = random_item();
            it.action = ACT_LOAD;
            return it;
        end
        if (roll < 70)
            return tame_process();
        it        = random_item();
        it.action = ACT_PROCESS;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: 64-bit two's complement with wrap throughout.
    // ------------------------------------------------------------------
    // Rounding right shift: shift by s-1 and halve; an odd value adds one to a non-negative
    // half and takes one from a negative half; amounts above 63 saturate at 63.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                       input logic [7:0] amount);
        logic signed [63:0] y;
        int unsigned        s;
        if (amount == 8'd0)
            return x;
        s = (amount > 8'd63) ? 63 : amount;
        y = x >>> (s - 1);
        if (!y[0])
            return y >>> 1;
        if (y[63])
            return (y >>> 1) - 64'sd1;
        return (y >>> 1) + 64'sd1;
    endfunction

    function automatic logic [7:0] predict_activation(input stage_item_t it);
        logic signed [63:0] acc;
        logic signed [63:0] term;
        logic signed [63:0] factor;
        logic signed [63:0] bn_value;
        logic signed [63:0] seg_start;
        logic signed [63:0] slope;
        logic signed [63:0] shaped;
        logic [59:0]        word;
        int                 sel;
        // zero-point corrections and per-input bias
        acc    = it.dot_product;
        term   = isum_gain;
        factor = it.sum_inputs;
        acc    = acc + ((term * factor) >>> isum_shift);
        term   = wsum_gain;
        factor = it.sum_weights;
        acc    = acc + ((term * factor) >>> wsum_shift);
        term   = bias_each;
        factor = group_inputs;
        acc    = acc + term * factor;
        // batch-norm
        factor   = it.bn_mul;
        bn_value = (acc * factor) >>> it.bn_shift;
        term     = it.bn_add;
        bn_value = bn_value + term;
        // highest-numbered segment whose start is not above the value
        sel = 0;
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            seg_start = $signed(seg_words[i][59:24]);
            if (seg_start <= bn_value)
                sel = i;
        end
        word      = seg_words[sel];
        seg_start = $signed(word[59:24]);
        slope     = $signed(word[23:8]);
        factor    = seg_offs[sel];
        shaped    = round_shift((bn_value - seg_start) * slope, word[7:0]) + factor;
        if (shaped < 0)
            return 8'd0;
        if (shaped > 255)
            return 8'd255;
        return shaped[7:0];
    endfunction

    // Apply one accepted transfer: a load updates the table, an accumulator
    // queues its predicted byte.
    task automatic absorb_item(input stage_item_t it);
        if (it.action == ACT_LOAD)
        begin
            if (it.segment_index < SEG_COUNT)
            begin
                seg_words[it.segment_index] = it.segment_word;
                seg_offs[it.segment_index]  = it.segment_offset;
            end
        end
        else
            expected_bytes.push_back(predict_activation(it));
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Register writes. Upper data bits beyond a register's width carry
    // random junk, which the block must drop.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                             input int bits);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        keep = (CFG_DATA_W'(1) << bits) - CFG_DATA_W'(1);
        data = (CFG_DATA_W'({$urandom, $urandom}) & ~keep) | (value & keep);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_WEIGHT_SUM_GAIN:  wsum_gain    = data[23:0];
            CFG_INPUT_SUM_GAIN:   isum_gain    = data[23:0];
            CFG_WEIGHT_SUM_SHIFT: wsum_shift   = data[3:0];
            CFG_INPUT_SUM_SHIFT:  isum_shift   = data[3:0];
            CFG_BIAS_PER_INPUT:   bias_each    = data[39:0];
            CFG_INPUTS_PER_GROUP: group_inputs = data[10:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input reg_setting_t kind);
        logic [23:0] wg;
        logic [23:0] ig;
        logic [3:0]  ws;
        logic [3:0]  ish;
        logic [39:0] bias;
        logic [10:0] grp;
        wg   = 24'(rand_pm(200));
        ig   = 24'(rand_pm(200));
        ws   = 4'($urandom);
        ish  = 4'($urandom);
        bias = 40'(rand_pm(1000));
        grp  = 11'($urandom_range(1, 1024));
        case (kind)
            SET_ALL_MAX:
            begin
                wg   = 24'h7f_ffff;
                ig   = 24'h7f_ffff;
                ws   = 4'd15;
                ish  = 4'd15;
                bias = 40'h7f_ffff_ffff;
                grp  = 11'd1024;
            end
            SET_ALL_MIN:
            begin
                wg   = 24'h80_0000;
                ig   = 24'h80_0000;
                ws   = 4'd0;
                ish  = 4'd0;
                bias = 40'h80_0000_0000;
                grp  = 11'd1;
            end
            SET_GROUP_ZERO: grp = 11'd0;
            SET_GROUP_WIDE: grp = 11'd2047;
            SET_RANDOM:
            begin
                wg   = 24'($urandom);
                ig   = 24'($urandom);
                bias = 40'({$urandom, $urandom});
                grp  = 11'($urandom);
            end
            default: ;
        endcase
        write_reg(CFG_WEIGHT_SUM_GAIN, CFG_DATA_W'(wg), 24);
        write_reg(CFG_INPUT_SUM_GAIN, CFG_DATA_W'(ig), 24);
        write_reg(CFG_WEIGHT_SUM_SHIFT, CFG_DATA_W'(ws), 4);
        write_reg(CFG_INPUT_SUM_SHIFT, CFG_DATA_W'(ish), 4);
        write_reg(CFG_BIAS_PER_INPUT, bias, 40);
        write_reg(CFG_INPUTS_PER_GROUP, CFG_DATA_W'(grp), 11);
        // spare indexes: the block must drop these writes
        write_reg(CFG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}), 40);
        write_reg(CFG_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}), 40);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every queued item has transferred and every
    // predicted byte has come out, then let a trailing load drain as well.
    task automatic settle();
        while (pending_items.size() != 0 || push || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending item whenever the port is free,
    // idling at random. An offered item holds until it transfers.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            items_in <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                absorb_item(offered);
                items_in <= items_in + 1;
            end
            if (!push || !full)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    push           <= 1'b1;
                    action         <= offered.action;
                    dot_product    <= offered.dot_product;
                    sum_inputs     <= offered.sum_inputs;
                    sum_weights    <= offered.sum_weights;
                    bn_mul         <= offered.bn_mul;
                    bn_add         <= offered.bn_add;
                    bn_shift       <= offered.bn_shift;
                    segment_index  <= offered.segment_index;
                    segment_word   <= offered.segment_word;
                    segment_offset <= offered.segment_offset;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off: once enough items have transferred, block
    // pop for a long stretch so the pipe, queue and buffer all fill and
    // full must rise while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_in >= HOLD_AT_ITEM)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: check each output transfer against the oldest prediction,
    // then decide pop for the next edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("activated %0d with nothing expected", activated));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (activated !== want)
                        report_mismatch($sformatf("activated %0d, expected %0d",
                                                  activated, want));
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Drop the run if it stalls far beyond the slowest correct schedule.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, then random phases under varied
    // register settings and idling patterns.
    // ------------------------------------------------------------------
    initial
    begin
        stage_item_t it;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(SET_TAME);

        // Load the whole table first; no accumulator may see an unwritten
        // segment. Segment 0 takes no rounding shift, segment 15 a shift far
        // above 63, and two offsets sit at the byte extremes.
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            it = tame_segment(i);
            if (i == 0)
                it.segment_word[7:0] = 8'd0;
            if (i == SEG_COUNT - 1)
                it.segment_word[7:0] = 8'd200;
            if (i == 3)
                it.segment_offset = 8'd255;
            if (i == 4)
                it.segment_offset = 8'd0;
            pending_items.push_back(it);
        end

        // With a zero multiplier the batch-norm value equals the addend,
        // which lets these items land on chosen segment boundaries.
        pending_items.push_back(process_item('0, '0, '0, 0, 32'sh8000_0000, 4'd0));
        pending_items.push_back(process_item('1, '0, '0, -3, 32'sh8000_0000, 4'd0));
        pending_items.push_back(process_item('0, '0, '0, 0, (7 <<< 28) + 12345, 4'd0));
        pending_items.push_back(process_item('0, '0, '0, 0, -(1 <<< 28), 4'd0));
        pending_items.push_back(process_item('0, '0, '0, 0, -1, 4'd0));
        pending_items.push_back(process_item('1, '1, '1, 24'sh7f_ffff, 32'sh7fff_ffff, 4'd15));
        pending_items.push_back(process_item('0, '0, '0, 0, 0, 4'd0));
        pending_items.push_back(process_item('1, '1, '1, 24'sh80_0000, 32'sh7fff_ffff, 4'd0));
        pending_items.push_back(process_item('1, '1, '0, -1, 0, 4'd15));
        settle();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            // sender idles lightly and receiver heavily, then the reverse,
            // then neither idles
            if (p < 2)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 81;
            end
            else if (p < 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(PHASE_PLAN[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_phase_item());
            settle();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
